// ===== rtl/set_assoc_cache_lru_timing_assert.svh =====
// Assertion macros for the cache back end.
`ifndef SET_ASSOC_CACHE_LRU_TIMING_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TIMING_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define SA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sacache_pkg.sv =====
// Shared types, register codes and helper functions of the cache model.
package sacache_pkg;

  // Register file codes, in port index order
  typedef enum logic [2:0] {
    CFG_OFFSET_BITS    = 3'd0,
    CFG_INDEX_BITS     = 3'd1,
    CFG_WAYS_IN_USE    = 3'd2,
    CFG_REPLACE_RANDOM = 3'd3,
    CFG_CACHE_CYCLES   = 3'd4,
    CFG_MEMORY_CYCLES  = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
    logic       replace_random;
    logic [9:0] cache_cycles;
    logic [9:0] memory_cycles;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    offset_bits:    4'd6,
    index_bits:     4'd4,
    ways_in_use:    4'd4,
    replace_random: 1'b0,
    cache_cycles:   10'd1,
    memory_cycles:  10'd100
  };

  // Raw set index before reduction: up to 15 index bits
  localparam int RAW_SET_W = 15;

  // Field widths fixed by the interface
  localparam int ADDR_W  = 48;
  localparam int CYC_W   = 11;
  localparam int CNT32_W = 32;
  localparam int CNT48_W = 48;

  // Replacement LFSR
  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Advance the LFSR once: taps 16,14,13,11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic b;
    b = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {b, s[LFSR_W-1:1]};
  endfunction

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back end sequencer
  typedef enum logic {
    BK_IDLE,
    BK_CALC
  } bk_state_t;

endpackage

// ===== rtl/sacache_fifo.sv =====
// Two-entry queue between the address front end and the lookup back end.
module sacache_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output sacache_pkg::q_stat_t stat
);

  logic [WIDTH-1:0] data [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) data[wr_ptr] <= push_data;
  end

  assign pop_data   = data[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

// ===== rtl/sacache_front.sv =====
// Front end: accepts access words, splits the address into set and tag.
module sacache_front #(
  parameter int MAX_SETS  = 256,
  parameter int ADDR_BITS = 48,
  localparam int AW     = (ADDR_BITS < sacache_pkg::ADDR_W) ? ADDR_BITS : sacache_pkg::ADDR_W,
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int ITEM_W = 1 + SET_W + AW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sacache_pkg::cfg_t              cfg,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           op,
  input  logic [sacache_pkg::ADDR_W-1:0] address,
  input  sacache_pkg::q_stat_t           q_stat,
  output logic                           q_push,
  output logic [ITEM_W-1:0]              q_data
);

  localparam int RW     = sacache_pkg::RAW_SET_W;
  // Reciprocal of the set count: quotient estimate is exact or one low
  localparam logic [16:0] RECIP = 17'((1 << 16) / MAX_SETS);
  localparam logic [RW-1:0] NSETS = RW'(MAX_SETS);

  logic          s1_vld;
  logic          s1_op;
  logic [RW-1:0] s1_raw;
  logic [AW-1:0] s1_tag;
  logic          s2_vld;
  logic          s2_op;
  logic [RW-1:0] s2_raw;
  logic [RW-1:0] s2_quo;
  logic [AW-1:0] s2_tag;

  logic          accept;
  logic          s1_move;
  logic          s2_free;
  logic [AW-1:0] addr_m;
  logic [AW-1:0] addr_sh;
  logic [4:0]    tag_sh;
  logic [RW-1:0] raw_set;
  logic [AW-1:0] tag;
  logic [32:0]   prod;
  logic [RW-1:0] rem_est;
  logic [RW-1:0] rem_fix;

  // Split the address
  always_comb begin
    addr_m  = address[AW-1:0];
    addr_sh = addr_m >> cfg.offset_bits;
    raw_set = addr_sh[RW-1:0] & ~({RW{1'b1}} << cfg.index_bits);
    tag_sh  = {1'b0, cfg.offset_bits} + {1'b0, cfg.index_bits};
    tag     = addr_m >> tag_sh;
  end

  // Handshake through the two stages
  assign q_push    = s2_vld && !q_stat.full;
  assign s2_free   = !s2_vld || q_push;
  assign s1_move   = s1_vld && s2_free;
  assign req_stall = s1_vld && !s1_move;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (accept)       s1_vld <= 1'b1;
      else if (s1_move) s1_vld <= 1'b0;
      if (s1_move)      s2_vld <= 1'b1;
      else if (q_push)  s2_vld <= 1'b0;
    end
  end

  // Estimate the quotient of the raw set by the set count
  assign prod = {18'd0, s1_raw} * {16'd0, RECIP};

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= op;
      s1_raw <= raw_set;
      s1_tag <= tag;
    end
    if (s1_move) begin
      s2_op  <= s1_op;
      s2_raw <= s1_raw;
      s2_quo <= prod[16 +: RW];
      s2_tag <= s1_tag;
    end
  end

  // Reduce modulo the set count with one correction step
  always_comb begin
    rem_est = s2_raw - RW'(s2_quo * NSETS);
    rem_fix = (rem_est >= NSETS) ? rem_est - NSETS : rem_est;
  end

  assign q_data = {s2_op, rem_fix[SET_W-1:0], s2_tag};

endmodule

// ===== rtl/sacache_modu.sv =====
// Remainder unit: reduces the next LFSR value modulo the way count.
module sacache_modu #(
  parameter int DIV_W = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sacache_pkg::LFSR_W-1:0] dividend,
  input  logic [DIV_W-1:0]               divisor,
  output logic                           done,
  output logic [DIV_W-1:0]               rem
);

  localparam int LW    = sacache_pkg::LFSR_W;
  localparam int CNT_W = $clog2(LW + 1);

  logic [LW-1:0]    x;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] rem_next;

  // One restoring step per cycle, top bit first
  always_comb begin
    trial    = {rem, x[LW-1]};
    rem_next = (trial >= {1'b0, divisor}) ? DIV_W'(trial - {1'b0, divisor})
                                          : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(LW);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      x   <= x << 1;
      rem <= rem_next;
    end
  end

  assign done = (cnt == '0);

endmodule

// ===== rtl/sacache_back.sv =====
// Back end: set lookup, victim choice, row write-back and running totals.
module sacache_back #(
  parameter int MAX_SETS  = 256,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48,
  localparam int AW     = (ADDR_BITS < sacache_pkg::ADDR_W) ? ADDR_BITS : sacache_pkg::ADDR_W,
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int ITEM_W = 1 + SET_W + AW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sacache_pkg::cfg_t               cfg,
  input  logic                            cfg_we,
  input  sacache_pkg::q_stat_t            q_stat,
  input  logic [ITEM_W-1:0]               q_data,
  output logic                            q_pop,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            hit,
  output logic                            eviction,
  output logic [sacache_pkg::CYC_W-1:0]   access_cycles,
  output logic [sacache_pkg::CNT32_W-1:0] hits_so_far,
  output logic [sacache_pkg::CNT32_W-1:0] misses_so_far,
  output logic [sacache_pkg::CNT32_W-1:0] evictions_so_far,
  output logic [sacache_pkg::CNT48_W-1:0] cycles_so_far
);

  `include "set_assoc_cache_lru_timing_assert.svh"

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RW     = WAY_W;
  localparam int CW     = $clog2(MAX_WAYS + 1);
  localparam int TAGS_W = MAX_WAYS * AW;
  localparam int RANK_W = MAX_WAYS * RW;
  localparam int ROW_W  = TAGS_W + RANK_W + CW;
  localparam int C32    = sacache_pkg::CNT32_W;
  localparam int C48    = sacache_pkg::CNT48_W;
  localparam int CYW    = sacache_pkg::CYC_W;
  localparam int LW     = sacache_pkg::LFSR_W;

  sacache_pkg::bk_state_t state, state_next;

  // Set rows: tags and ranks of every way, and the fill count
  logic [ROW_W-1:0]    row_mem [MAX_SETS];
  logic [ROW_W-1:0]    rd_row;
  logic [MAX_SETS-1:0] set_seen;

  logic          cur_op;
  logic [SET_W-1:0] cur_set;
  logic [AW-1:0] cur_tag;
  logic [LW-1:0] lfsr;
  logic          mod_kick;
  logic          mod_done;
  logic [CW-1:0] mod_rem;
  logic          mod_ready;

  logic [C32-1:0] hit_total;
  logic [C32-1:0] miss_total;
  logic [C32-1:0] evict_total;
  logic [C48-1:0] cycle_total;

  logic                          pop_now;
  logic                          commit;
  logic                          out_free;
  logic [CW-1:0]                 nways;
  logic [MAX_WAYS-1:0][AW-1:0]   rd_tags;
  logic [MAX_WAYS-1:0][RW-1:0]   rd_rank;
  logic [CW-1:0]                 rd_fill;
  logic                          seen;
  logic [MAX_WAYS-1:0][RW-1:0]   rank;
  logic [CW-1:0]                 fill;
  logic [MAX_WAYS-1:0]           inuse;
  logic [MAX_WAYS-1:0]           vld;
  logic [MAX_WAYS-1:0]           match;
  logic                          is_hit;
  logic [WAY_W-1:0]              hit_way;
  logic                          found_free;
  logic                          is_evict;
  logic [WAY_W-1:0]              lru_way;
  logic [WAY_W-1:0]              way_sel;
  logic [CW-1:0]                 old_rank;
  logic [CW-1:0]                 top_rank;
  logic [MAX_WAYS-1:0][RW-1:0]   new_rank;
  logic [MAX_WAYS-1:0][AW-1:0]   new_tags;
  logic [CW-1:0]                 new_fill;
  logic                          need_mod;
  logic                          lfsr_adv;
  logic [CYW-1:0]                cyc;
  logic [C48:0]                  cyc_sum;

  // Clamp the way count into one through MAX_WAYS
  always_comb begin
    if (cfg.ways_in_use == 4'd0) begin
      nways = CW'(1);
    end else if ({1'b0, cfg.ways_in_use} > 5'(MAX_WAYS)) begin
      nways = CW'(MAX_WAYS);
    end else begin
      nways = CW'(cfg.ways_in_use);
    end
  end

  // Unpack the row; a set never written reads as empty
  assign rd_tags = rd_row[ROW_W-1 -: TAGS_W];
  assign rd_rank = rd_row[CW +: RANK_W];
  assign rd_fill = rd_row[CW-1:0];
  assign seen    = set_seen[cur_set];
  assign rank    = seen ? rd_rank : '0;
  assign fill    = seen ? rd_fill : '0;

  // Look up the tag and choose the way to touch
  always_comb begin
    hit_way = '0;
    lru_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      inuse[w] = CW'(w) < nways;
      vld[w]   = CW'(w) < fill;
      match[w] = inuse[w] && vld[w] && (rd_tags[w] == cur_tag);
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (inuse[w] && rank[w] > rank[lru_way]) lru_way = WAY_W'(w);
    end
    is_hit     = |match;
    found_free = fill < nways;
    is_evict   = !is_hit && !found_free;
    priority if (is_hit)         way_sel = hit_way;
    else if (found_free)         way_sel = fill[WAY_W-1:0];
    else if (cfg.replace_random) way_sel = mod_rem[WAY_W-1:0];
    else                         way_sel = lru_way;
  end

  // Age the more recent ways and move the touched way to the front
  always_comb begin
    old_rank = is_hit ? CW'(rank[hit_way]) : nways;
    top_rank = nways - CW'(1);
    new_tags = rd_tags;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WAY_W'(v) == way_sel) begin
        new_rank[v] = '0;
      end else if (inuse[v] && vld[v] && CW'(rank[v]) < old_rank
                   && CW'(rank[v]) < top_rank) begin
        new_rank[v] = rank[v] + RW'(1);
      end else begin
        new_rank[v] = rank[v];
      end
    end
    if (!is_hit) new_tags[way_sel] = cur_tag;
    new_fill = (!is_hit && found_free) ? fill + CW'(1) : fill;
  end

  // Charge the access
  always_comb begin
    cyc = CYW'(cfg.cache_cycles);
    if (cur_op || !is_hit) cyc = cyc + CYW'(cfg.memory_cycles);
    cyc_sum = {1'b0, cycle_total} + (C48 + 1)'(cyc);
  end

  // Sequence one lookup and one write-back per word
  assign out_free = !rsp_valid || !rsp_stall;
  assign need_mod = is_evict && cfg.replace_random;
  assign pop_now  = (state == sacache_pkg::BK_IDLE) && !q_stat.empty;
  assign commit   = (state == sacache_pkg::BK_CALC) && out_free && (!need_mod || mod_ready);
  assign lfsr_adv = commit && need_mod;
  assign q_pop    = pop_now;

  always_comb begin
    state_next = state;
    unique case (state)
      sacache_pkg::BK_IDLE: begin
        if (pop_now) state_next = sacache_pkg::BK_CALC;
      end
      sacache_pkg::BK_CALC: begin
        if (commit) state_next = sacache_pkg::BK_IDLE;
      end
      default: state_next = sacache_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacache_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the popped word and read its set row
  always_ff @(posedge clk) begin
    if (pop_now) begin
      {cur_op, cur_set, cur_tag} <= q_data;
      rd_row <= row_mem[q_data[AW +: SET_W]];
    end
    if (commit) row_mem[cur_set] <= {new_tags, new_rank, new_fill};
  end

  // Mark written sets; hold the LFSR and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      set_seen    <= '0;
      lfsr        <= sacache_pkg::LFSR_SEED;
      mod_kick    <= 1'b1;
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
      cycle_total <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      mod_kick  <= cfg_we || lfsr_adv;
      rsp_valid <= commit || (rsp_valid && rsp_stall);
      if (commit) begin
        set_seen[cur_set] <= 1'b1;
        if (lfsr_adv) lfsr <= sacache_pkg::lfsr_step(lfsr);
        if (is_hit) begin
          if (hit_total != '1) hit_total <= hit_total + C32'(1);
        end else begin
          if (miss_total != '1) miss_total <= miss_total + C32'(1);
        end
        if (is_evict && evict_total != '1) evict_total <= evict_total + C32'(1);
        cycle_total <= cyc_sum[C48] ? '1 : cyc_sum[C48-1:0];
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (commit) begin
      hit           <= is_hit;
      eviction      <= is_evict;
      access_cycles <= cyc;
    end
  end

  assign hits_so_far      = hit_total;
  assign misses_so_far    = miss_total;
  assign evictions_so_far = evict_total;
  assign cycles_so_far    = cycle_total;

  // Precompute the random victim for the next LFSR value
  assign mod_ready = mod_done && !mod_kick;

  sacache_modu #(
    .DIV_W (CW)
  ) u_modu (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_kick),
    .dividend (sacache_pkg::lfsr_step(lfsr)),
    .divisor  (nways),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  `SA_ASSERT_NOW(a_rand_victim_ready, clk, rst, lfsr_adv, mod_ready,
                 "random victim used before remainder was ready")
  `SA_ASSERT_NEXT(a_commit_shows_word, clk, rst, commit,
                  rsp_valid && state == sacache_pkg::BK_IDLE, "committed word not presented")
  `SA_ASSERT_NOW(a_hit_not_evict, clk, rst, rsp_valid, !(hit && eviction),
                 "hit and eviction reported together")
  `SA_ASSERT_NOW(a_fill_bound, clk, rst, commit, new_fill <= CW'(MAX_WAYS),
                 "fill count beyond way count")

endmodule

// ===== rtl/set_assoc_cache_lru_timing.sv =====
// Set-associative cache tag model with LRU or random replacement: the access
// word is accepted by a two-stage front end that splits the address into set
// and tag (reducing the set index modulo MAX_SETS), then queued in a two-entry
// queue for the back end, which takes one access at a time: its idle state
// pops it and reads the set row (all tags, LRU ranks and fill count) from its
// single-port row memory, its calc state compares, chooses the way, writes the
// row back and loads the result word. A random eviction needs the next LFSR
// value modulo the way count, worked out by a one-bit-per-cycle remainder unit
// after each random eviction or register write; an early eviction waits for it.
// Running totals saturate at their maximum. The user must see that registers are
// written only while the block is idle; the block itself does not enforce it.
module set_assoc_cache_lru_timing #(
  parameter int MAX_SETS  = 256,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               op,
  input  logic [sacache_pkg::ADDR_W-1:0]     address,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               hit,
  output logic                               eviction,
  output logic [sacache_pkg::CYC_W-1:0]      access_cycles,
  output logic [sacache_pkg::CNT32_W-1:0]    hits_so_far,
  output logic [sacache_pkg::CNT32_W-1:0]    misses_so_far,
  output logic [sacache_pkg::CNT32_W-1:0]    evictions_so_far,
  output logic [sacache_pkg::CNT48_W-1:0]    cycles_so_far
);

  localparam int AW     = (ADDR_BITS < sacache_pkg::ADDR_W) ? ADDR_BITS : sacache_pkg::ADDR_W;
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ITEM_W = 1 + SET_W + AW;

  sacache_pkg::cfg_t    cfg;
  sacache_pkg::q_stat_t q_stat;
  logic                 q_push;
  logic                 q_pop;
  logic [ITEM_W-1:0]    q_wdata;
  logic [ITEM_W-1:0]    q_rdata;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sacache_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacache_pkg::CFG_OFFSET_BITS:    cfg.offset_bits    <= cfg_data[3:0];
        sacache_pkg::CFG_INDEX_BITS:     cfg.index_bits     <= cfg_data[3:0];
        sacache_pkg::CFG_WAYS_IN_USE:    cfg.ways_in_use    <= cfg_data[3:0];
        sacache_pkg::CFG_REPLACE_RANDOM: cfg.replace_random <= cfg_data[0];
        sacache_pkg::CFG_CACHE_CYCLES:   cfg.cache_cycles   <= cfg_data[9:0];
        sacache_pkg::CFG_MEMORY_CYCLES:  cfg.memory_cycles  <= cfg_data[9:0];
        default: cfg <= cfg;
      endcase
    end
  end

  sacache_front #(
    .MAX_SETS  (MAX_SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .address   (address),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  sacache_fifo #(
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  sacache_back #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cfg_we           (cfg_we),
    .q_stat           (q_stat),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .hit              (hit),
    .eviction         (eviction),
    .access_cycles    (access_cycles),
    .hits_so_far      (hits_so_far),
    .misses_so_far    (misses_so_far),
    .evictions_so_far (evictions_so_far),
    .cycles_so_far    (cycles_so_far)
  );

endmodule

// ===== test/set_assoc_cache_lru_timing_checker.sv =====
// Checker for the cache tag model: predicts each access result and compares it with the block.
`timescale 1ns / 1ps

module set_assoc_cache_lru_timing_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               req_valid,
  input  logic                               req_stall,
  input  logic                               op,
  input  logic [sacache_pkg::ADDR_W-1:0]     address,
  input  logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  logic                               hit,
  input  logic                               eviction,
  input  logic [sacache_pkg::CYC_W-1:0]      access_cycles,
  input  logic [sacache_pkg::CNT32_W-1:0]    hits_so_far,
  input  logic [sacache_pkg::CNT32_W-1:0]    misses_so_far,
  input  logic [sacache_pkg::CNT32_W-1:0]    evictions_so_far,
  input  logic [sacache_pkg::CNT48_W-1:0]    cycles_so_far,
  output int                                 fails,
  output int                                 pending
);

  localparam int SETS  = 256;
  localparam int WAYS  = 8;
  localparam int SLOTS = SETS * WAYS;

  typedef struct packed {
    logic                            hit;
    logic                            eviction;
    logic [sacache_pkg::CYC_W-1:0]   cycles;
    logic [sacache_pkg::CNT32_W-1:0] hits;
    logic [sacache_pkg::CNT32_W-1:0] misses;
    logic [sacache_pkg::CNT32_W-1:0] evicts;
    logic [sacache_pkg::CNT48_W-1:0] cycle_sum;
  } access_result_t;

  // Shadow copy of the cache state and registers
  sacache_pkg::cfg_t               regs;
  logic [sacache_pkg::ADDR_W-1:0]  tag_mem   [SLOTS];
  logic                            valid_mem [SLOTS];
  logic [2:0]                      rank_mem  [SLOTS];
  logic [sacache_pkg::LFSR_W-1:0]  victim_lfsr;
  logic [sacache_pkg::CNT32_W-1:0] hit_count, miss_count, evict_count;
  logic [sacache_pkg::CNT48_W-1:0] cycle_count;
  access_result_t                  expected_results[$];

  assign pending = expected_results.size();

  task automatic report_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
    $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    fails++;
  endtask

  // Move a way to most recent; age the valid ways that were more recent than it
  function automatic void promote_way(input int base, input int nways, input int way,
                                      input int old_rank);
    for (int v = 0; v < nways; v++) begin
      if (v != way && valid_mem[base + v] && int'(rank_mem[base + v]) < old_rank
          && int'(rank_mem[base + v]) < nways - 1)
        rank_mem[base + v] = rank_mem[base + v] + 3'd1;
    end
    rank_mem[base + way] = 3'd0;
  endfunction

  // Look up one access, update the shadow state and return its result
  function automatic access_result_t lookup_access(
      input logic is_write, input logic [sacache_pkg::ADDR_W-1:0] addr);
    access_result_t r;
    int nways, base, way, shift;
    logic [sacache_pkg::ADDR_W-1:0] raw_set, tag;
    logic found, free_way, evicted;
    logic [sacache_pkg::CYC_W-1:0] cyc;
    logic [sacache_pkg::CNT48_W:0] sum;
    logic fb;

    nways = int'(regs.ways_in_use);
    if (nways == 0) nways = 1;
    if (nways > WAYS) nways = WAYS;
    raw_set = (addr >> regs.offset_bits) & ((48'd1 << regs.index_bits) - 48'd1);
    shift   = int'(regs.offset_bits) + int'(regs.index_bits);
    tag     = addr >> shift;
    base    = int'(raw_set[7:0]) * WAYS;
    found    = 1'b0;
    free_way = 1'b0;
    evicted  = 1'b0;
    way      = 0;

    for (int w = 0; w < nways; w++) begin
      if (!found && valid_mem[base + w] && tag_mem[base + w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end

    if (found) begin
      if (hit_count != '1) hit_count++;
      promote_way(base, nways, way, int'(rank_mem[base + way]));
    end else begin
      if (miss_count != '1) miss_count++;
      for (int w = 0; w < nways; w++) begin
        if (!free_way && !valid_mem[base + w]) begin
          free_way = 1'b1;
          way      = w;
        end
      end
      if (!free_way) begin
        evicted = 1'b1;
        if (evict_count != '1) evict_count++;
        if (regs.replace_random) begin
          // step the victim LFSR, then take it modulo the way count
          fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
          victim_lfsr = {fb, victim_lfsr[sacache_pkg::LFSR_W-1:1]};
          way = int'(victim_lfsr) % nways;
        end else begin
          way = 0;
          for (int w = 1; w < nways; w++)
            if (rank_mem[base + w] > rank_mem[base + way]) way = w;
        end
      end
      tag_mem[base + way]   = tag;
      valid_mem[base + way] = 1'b1;
      promote_way(base, nways, way, nways);
    end

    if (is_write || !found) cyc = {1'b0, regs.cache_cycles} + {1'b0, regs.memory_cycles};
    else cyc = {1'b0, regs.cache_cycles};
    sum = {1'b0, cycle_count} + (sacache_pkg::CNT48_W + 1)'(cyc);
    cycle_count = sum[sacache_pkg::CNT48_W] ? '1 : sum[sacache_pkg::CNT48_W-1:0];

    r.hit       = found;
    r.eviction  = evicted;
    r.cycles    = cyc;
    r.hits      = hit_count;
    r.misses    = miss_count;
    r.evicts    = evict_count;
    r.cycle_sum = cycle_count;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    access_result_t want;
    access_result_t next_want;

    if (rst) begin
      fails       = 0;
      regs        = sacache_pkg::CFG_RESET;
      victim_lfsr = sacache_pkg::LFSR_SEED;
      hit_count   = '0;
      miss_count  = '0;
      evict_count = '0;
      cycle_count = '0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_mem[i] = 1'b0;
        rank_mem[i]  = 3'd0;
      end
      expected_results.delete();
    end else begin
      // register writes must land only while the block is idle; nothing here checks it
      if (cfg_we) begin
        unique case (cfg_index)
          sacache_pkg::CFG_OFFSET_BITS:    regs.offset_bits    = cfg_data[3:0];
          sacache_pkg::CFG_INDEX_BITS:     regs.index_bits     = cfg_data[3:0];
          sacache_pkg::CFG_WAYS_IN_USE:    regs.ways_in_use    = cfg_data[3:0];
          sacache_pkg::CFG_REPLACE_RANDOM: regs.replace_random = cfg_data[0];
          sacache_pkg::CFG_CACHE_CYCLES:   regs.cache_cycles   = cfg_data[9:0];
          sacache_pkg::CFG_MEMORY_CYCLES:  regs.memory_cycles  = cfg_data[9:0];
          default: ;
        endcase
      end

      // compare a delivered result word with the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no access outstanding", '0, cycles_so_far);
        end else begin
          want = expected_results.pop_front();
          if (hit != want.hit) report_mismatch("hit", 48'(want.hit), 48'(hit));
          if (eviction != want.eviction)
            report_mismatch("eviction", 48'(want.eviction), 48'(eviction));
          if (access_cycles != want.cycles)
            report_mismatch("access_cycles", 48'(want.cycles), 48'(access_cycles));
          if (hits_so_far != want.hits)
            report_mismatch("hits_so_far", 48'(want.hits), 48'(hits_so_far));
          if (misses_so_far != want.misses)
            report_mismatch("misses_so_far", 48'(want.misses), 48'(misses_so_far));
          if (evictions_so_far != want.evicts)
            report_mismatch("evictions_so_far", 48'(want.evicts), 48'(evictions_so_far));
          if (cycles_so_far != want.cycle_sum)
            report_mismatch("cycles_so_far", want.cycle_sum, cycles_so_far);
        end
      end

      // predict the result of each accepted access word
      if (req_valid && !req_stall) begin
        next_want = lookup_access(op, address);
        expected_results.insert(expected_results.size(), next_want);
      end
    end
  end

endmodule

// ===== test/set_assoc_cache_lru_timing_tb.sv =====
// Testbench top for the cache tag model: clock, reset, access stimulus and verdict.
`timescale 1ns / 1ps

module set_assoc_cache_lru_timing_tb;

  localparam logic OP_READ    = 1'b0;
  localparam logic OP_WRITE   = 1'b1;
  localparam int   IDLE_LIMIT = 20000;
  localparam int   HOLD_OFF   = 150;
  localparam int   SETTLE     = 40;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_we;
  logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                               req_valid;
  logic                               req_stall;
  logic                               op;
  logic [sacache_pkg::ADDR_W-1:0]     address;
  logic                               rsp_valid;
  logic                               rsp_stall = 1'b0;
  logic                               hit;
  logic                               eviction;
  logic [sacache_pkg::CYC_W-1:0]      access_cycles;
  logic [sacache_pkg::CNT32_W-1:0]    hits_so_far;
  logic [sacache_pkg::CNT32_W-1:0]    misses_so_far;
  logic [sacache_pkg::CNT32_W-1:0]    evictions_so_far;
  logic [sacache_pkg::CNT48_W-1:0]    cycles_so_far;
  int                                 fails;
  int                                 pending;

  // Stimulus controls shared with the receiver
  bit steady     = 1'b0;
  int hold_asked = 0;
  int hold_done  = 0;
  int cur_off, cur_idx;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  set_assoc_cache_lru_timing DUT (.*);

  set_assoc_cache_lru_timing_checker checker_i (.*);

  // Receiver: random stalls, or one long hold-off when asked
  always begin
    @(negedge clk);
    if (hold_done != hold_asked) begin
      hold_done = hold_done + 1;
      rsp_stall <= 1'b1;
      repeat (HOLD_OFF) @(negedge clk);
    end
    rsp_stall <= !steady && ($urandom_range(99) < 17);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [47:0] r;
    r[47:32] = 16'($urandom_range(16'hFFFF));
    r[31:0]  = $urandom;
    return r;
  endfunction

  // Offer one access word and hold it until accepted
  task automatic send_word(input logic wr, input logic [47:0] addr);
    while (!steady && $urandom_range(99) < 17) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    op        <= wr;
    address   <= addr;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input sacache_pkg::cfg_idx_t r, input logic [9:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  // Reprogram the block, then run random accesses over a small tag and set pool
  task automatic run_phase(input logic [9:0] off, input logic [9:0] idx,
                           input logic [9:0] ways, input logic [9:0] rnd,
                           input logic [9:0] cc, input logic [9:0] mc,
                           input int count, input bit calm, input bit hold);
    logic [47:0] tags [16];
    logic [47:0] sets [4];
    logic [47:0] a, set_mask, low_mask;
    int ntags, shift;

    drain();
    write_reg(sacache_pkg::CFG_OFFSET_BITS, off);
    write_reg(sacache_pkg::CFG_INDEX_BITS, idx);
    write_reg(sacache_pkg::CFG_WAYS_IN_USE, ways);
    write_reg(sacache_pkg::CFG_REPLACE_RANDOM, rnd);
    write_reg(sacache_pkg::CFG_CACHE_CYCLES, cc);
    write_reg(sacache_pkg::CFG_MEMORY_CYCLES, mc);
    cfg_we <= 1'b0;

    cur_off  = int'(off[3:0]);
    cur_idx  = int'(idx[3:0]);
    shift    = cur_off + cur_idx;
    set_mask = (48'd1 << cur_idx) - 48'd1;
    low_mask = (48'd1 << cur_off) - 48'd1;
    ntags    = int'($urandom_range(3, 16));
    for (int i = 0; i < 16; i++) tags[i] = rand48();
    for (int i = 0; i < 4; i++) sets[i] = rand48();
    steady = calm;
    if (hold) hold_asked = hold_asked + 1;

    // mostly reuse of a few blocks so that hits and evictions both happen
    repeat (count) begin
      if ($urandom_range(99) < 20) a = rand48();
      else a = (tags[$urandom_range(ntags - 1)] << shift)
               | ((sets[$urandom_range(3)] & set_mask) << cur_off)
               | (rand48() & low_mask);
      send_word(1'($urandom_range(1)), a);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = sacache_pkg::CFG_OFFSET_BITS;
    cfg_data  = '0;
    req_valid = 1'b0;
    op        = OP_READ;
    address   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset split is 6 offset bits and 4 index bits, four ways, LRU
    send_word(OP_READ, 48'h0);              // cold miss fills way 0
    send_word(OP_READ, 48'h0);              // hit
    send_word(OP_WRITE, 48'h0);             // write hit pays memory too
    send_word(OP_WRITE, 48'hFFFF_FFFF_FFFF);
    send_word(OP_READ, 48'h0000_0000_0400);
    send_word(OP_READ, 48'h0000_0000_0800);
    send_word(OP_READ, 48'h0000_0000_0C00); // set 0 now full
    send_word(OP_READ, 48'h0000_0000_0000); // hit reorders LRU
    send_word(OP_READ, 48'h0000_0000_1000); // evicts least recent
    send_word(OP_READ, 48'h0000_0000_0400); // evicted earlier, misses again
    send_word(OP_READ, 48'h0000_0000_003F); // offset bits ignored
    send_word(OP_WRITE, 48'h0000_0000_1400);
    send_word(OP_READ, 48'h8000_0000_0000);
    send_word(OP_READ, 48'hFFFF_FFFF_FFC0);
    send_word(OP_WRITE, 48'hFFFF_FFFF_FFFF);
    send_word(OP_READ, 48'h5555_5555_5555);
    send_word(OP_WRITE, 48'hAAAA_AAAA_AAAA);

    // Extreme and mixed register settings
    run_phase(10'd0, 10'd0, 10'd1, 10'd0, 10'd0, 10'd0, 180, 1'b0, 1'b0);
    run_phase(10'd15, 10'd15, 10'd8, 10'd1, 10'd1023, 10'd1023, 180, 1'b0, 1'b1);
    run_phase(10'd12, 10'd8, 10'd0, 10'd1, 10'd5, 10'd50, 180, 1'b1, 1'b0);
    run_phase(10'd3, 10'd2, 10'd13, 10'd0, 10'd1023, 10'd0, 180, 1'b0, 1'b0);
    run_phase(10'd6, 10'd3, 10'd3, 10'd1, 10'd0, 10'd1023, 180, 1'b0, 1'b0);
    run_phase(10'd4, 10'd1, 10'd5, 10'd0, 10'd7, 10'd93, 180, 1'b0, 1'b0);
    repeat (2)
      run_phase(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                180, 1'b0, 1'b0);

    drain();
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
